@@ rtl/core/flcms_pkg.sv @@
package flcms_pkg;

    localparam int NUM_LEVELS   = 5;
    localparam int LEVEL_W      = 3;
    localparam int HANDLE_W     = 16;
    localparam int CREDIT_W     = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 24;

    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [CREDIT_W-1:0] credit_t;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_REQUEUE = 2'd2,
        OP_FLUSH   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NO_GRANT = 2'd3
    } status_t;

    localparam level_t LEVEL_BASE = 3'd0;
    localparam level_t LEVEL_LOW  = 3'd1;
    localparam level_t LEVEL_MID  = 3'd2;
    localparam level_t LEVEL_HIGH = 3'd3;
    localparam level_t LEVEL_TOP  = 3'd4;
    localparam level_t LEVEL_NONE = 3'd5;

    localparam credit_t CREDIT_RESET = 8'd10;

    localparam logic [CFG_INDEX_W-1:0] CFG_RELOAD_HIGH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELOAD_MID  = 2'd1;

endpackage

@@ rtl/core/five_level_credit_message_scheduler_core.sv @@
// five-level message scheduler: level 4 strict, levels 3 and 2 credited, then 1 and 0
// s_ channel: one command per transaction (enqueue, dequeue, requeue to front, flush level 4)
// m_ channel: exactly one result per command, in command order
// cfg channel: index 0 sets the level 3 credit reload, index 1 the level 2 reload;
//   ready whenever reset is not asserted, write only while no command is in flight
// pipeline: a command accepted into the input register passes through the decision
//   logic and the handle memory read into the result register
// throughput: one command per cycle unless a stall holds the pipeline; the single handle
//   memory has one write and one read port, and every command uses at most one of each
// reset: all levels empty, both credits and both reload values at 10, no level
//   served yet; handle memory contents are not cleared; s_tready and cfg_ready
//   stay low while aresetn is low
// stall: while m_tvalid is high and m_tready low the result holds, s_tready drops
//   and the whole pipeline freezes until the result is taken
module five_level_credit_message_scheduler_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // op[1:0], level[4:2], handle[20:5], working[21], zero fill
    input  logic [flcms_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // granted[0], out_handle[16:1], out_level[19:17], status[21:20], any_queued[22], zero fill
    output logic [flcms_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [flcms_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [flcms_pkg::CREDIT_W-1:0]     cfg_data
);
    import flcms_pkg::*;

    localparam int HW        = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [SUM_W-1:0] SUM_WRAP = SUM_W'(QUEUE_DEPTH);

    // input register
    logic            in_valid_reg;
    op_t             in_op_reg;
    level_t          in_level_reg;
    logic [HW-1:0]   in_handle_reg;
    logic            in_working_reg;

    // scheduler state
    logic [PTR_W-1:0] head_reg  [NUM_LEVELS];
    logic [PTR_W-1:0] head_next [NUM_LEVELS];
    logic [CNT_W-1:0] count_reg  [NUM_LEVELS];
    logic [CNT_W-1:0] count_next [NUM_LEVELS];
    credit_t          credit_high_reg, credit_high_next;
    credit_t          credit_mid_reg, credit_mid_next;
    level_t           last_level_reg, last_level_next;
    credit_t          reload_high_reg;
    credit_t          reload_mid_reg;

    // handle memory
    logic [HW-1:0]     mem [MEM_DEPTH];
    logic [HW-1:0]     rdata_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // result register
    logic     out_valid_reg;
    logic     out_granted_reg, granted_next;
    level_t   out_level_reg, out_level_next;
    status_t  out_status_reg, status_next;
    logic     out_any_reg, any_next;

    logic     en;
    logic     step;

    assign en        = !out_valid_reg || m_tready;
    assign step      = en && in_valid_reg;
    assign s_tready  = en && aresetn;
    assign cfg_ready = aresetn;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_any_reg, out_status_reg, out_level_reg,
                        out_granted_reg ? HANDLE_W'(rdata_reg) : HANDLE_W'(0),
                        out_granted_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
        if (en) begin
            in_op_reg      <= op_t'(s_tdata[1:0]);
            in_level_reg   <= s_tdata[4:2];
            in_handle_reg  <= s_tdata[5 +: HW];
            in_working_reg <= s_tdata[21];
        end
    end

    always_comb begin
        logic [NUM_LEVELS-1:0] held;
        level_t                pick;
        level_t                lv;
        logic [SUM_W-1:0]      tail_sum;
        logic [PTR_W-1:0]      idx;

        for (int i = 0; i < NUM_LEVELS; i++) begin
            held[i]       = (count_reg[i] != '0);
            head_next[i]  = head_reg[i];
            count_next[i] = count_reg[i];
        end
        credit_high_next = credit_high_reg;
        credit_mid_next  = credit_mid_reg;
        last_level_next  = last_level_reg;
        granted_next     = 1'b0;
        out_level_next   = LEVEL_BASE;
        status_next      = ST_OK;
        wr_en            = 1'b0;
        wr_addr          = '0;
        rd_addr          = '0;
        pick             = LEVEL_NONE;
        lv               = in_level_reg;
        tail_sum         = '0;
        idx              = '0;

        case (in_op_reg)
            OP_ENQUEUE: begin
                if (in_level_reg > LEVEL_TOP || count_reg[lv] == CNT_FULL) begin
                    status_next = ST_DROPPED;
                end else begin
                    tail_sum = SUM_W'(head_reg[lv]) + SUM_W'(count_reg[lv]);
                    if (tail_sum >= SUM_WRAP) begin
                        tail_sum = tail_sum - SUM_WRAP;
                    end
                    idx            = tail_sum[PTR_W-1:0];
                    wr_en          = step;
                    wr_addr        = ADDR_W'(ADDR_W'(lv) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(idx);
                    count_next[lv] = count_reg[lv] + 1'b1;
                end
            end
            OP_DEQUEUE: begin
                if (held[LEVEL_TOP]) begin
                    pick = LEVEL_TOP;
                end else if (in_working_reg) begin
                    if (credit_high_reg != '0 && held[LEVEL_HIGH]) begin
                        pick             = LEVEL_HIGH;
                        credit_high_next = credit_high_reg - 1'b1;
                    end else begin
                        credit_high_next = reload_high_reg;
                        if (credit_mid_reg != '0 && held[LEVEL_MID]) begin
                            pick            = LEVEL_MID;
                            credit_mid_next = credit_mid_reg - 1'b1;
                        end else begin
                            credit_mid_next = reload_mid_reg;
                            if (held[LEVEL_LOW]) begin
                                pick = LEVEL_LOW;
                            end else if (held[LEVEL_BASE]) begin
                                pick = LEVEL_BASE;
                            end else if (held[LEVEL_HIGH] || held[LEVEL_MID]) begin
                                // second pass with both credits freshly reloaded
                                if (reload_high_reg != '0 && held[LEVEL_HIGH]) begin
                                    pick             = LEVEL_HIGH;
                                    credit_high_next = reload_high_reg - 1'b1;
                                end else if (reload_mid_reg != '0 && held[LEVEL_MID]) begin
                                    pick            = LEVEL_MID;
                                    credit_mid_next = reload_mid_reg - 1'b1;
                                end
                            end
                        end
                    end
                end
                if (pick != LEVEL_NONE) begin
                    rd_addr = ADDR_W'(ADDR_W'(pick) * ADDR_W'(QUEUE_DEPTH))
                            + ADDR_W'(head_reg[pick]);
                    head_next[pick]  = (head_reg[pick] == PTR_LAST) ? '0
                                     : head_reg[pick] + 1'b1;
                    count_next[pick] = count_reg[pick] - 1'b1;
                    last_level_next  = pick;
                    granted_next     = 1'b1;
                    out_level_next   = pick;
                end else begin
                    status_next = ST_EMPTY;
                end
            end
            OP_REQUEUE: begin
                lv = last_level_reg;
                if (last_level_reg == LEVEL_NONE) begin
                    status_next = ST_NO_GRANT;
                end else if (count_reg[lv] == CNT_FULL) begin
                    status_next = ST_DROPPED;
                end else begin
                    idx            = (head_reg[lv] == '0) ? PTR_LAST : head_reg[lv] - 1'b1;
                    head_next[lv]  = idx;
                    wr_en          = step;
                    wr_addr        = ADDR_W'(ADDR_W'(lv) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(idx);
                    count_next[lv] = count_reg[lv] + 1'b1;
                end
            end
            OP_FLUSH: begin
                count_next[LEVEL_TOP] = '0;
                head_next[LEVEL_TOP]  = '0;
            end
            default: begin
                status_next = ST_OK;
            end
        endcase

        any_next = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            any_next = any_next | (count_next[i] != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_handle_reg;
        end
        if (en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            credit_high_reg <= CREDIT_RESET;
            credit_mid_reg  <= CREDIT_RESET;
            last_level_reg  <= LEVEL_NONE;
        end else if (step) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i]  <= head_next[i];
                count_reg[i] <= count_next[i];
            end
            credit_high_reg <= credit_high_next;
            credit_mid_reg  <= credit_mid_next;
            last_level_reg  <= last_level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_high_reg <= CREDIT_RESET;
            reload_mid_reg  <= CREDIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RELOAD_HIGH: reload_high_reg <= cfg_data;
                CFG_RELOAD_MID:  reload_mid_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= in_valid_reg;
        end
        if (step) begin
            out_granted_reg <= granted_next;
            out_level_reg   <= out_level_next;
            out_status_reg  <= status_next;
            out_any_reg     <= any_next;
        end
    end

endmodule
